// ----- design/ccc_pkg.sv -----
package ccc_pkg;

   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int DIST_W  = 18;
   localparam int LABEL_W = 8;
   localparam int TOTAL_W = 9;
   localparam int THR_W   = 9;

   localparam logic [THR_W-1:0]  THR_RESET    = 9'd150;
   localparam logic [DIST_W-1:0] THR_SQ_RESET = 18'd22500;

   typedef struct packed {
      logic clear;
      logic load;
   } dist_ctl_type;

   function automatic logic [2*CH_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
      logic [CH_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return (2*CH_W)'(d) * (2*CH_W)'(d);
   endfunction

endpackage

// ----- design/ccc_req_if.sv -----
interface ccc_req_if;
   logic                      valid;
   logic                      ready;
   logic                      start_req;
   logic [ccc_pkg::CH_W-1:0]  blue;
   logic [ccc_pkg::CH_W-1:0]  green;
   logic [ccc_pkg::CH_W-1:0]  red;

   modport source (output valid, start_req, blue, green, red, input ready);
   modport sink   (input valid, start_req, blue, green, red, output ready);
endinterface

// ----- design/ccc_rsp_if.sv -----
interface ccc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ccc_pkg::LABEL_W-1:0]   label;
   logic                          opened;
   logic                          overflow;
   logic [ccc_pkg::TOTAL_W-1:0]   cluster_total;

   modport source (output valid, label, opened, overflow, cluster_total, input ready);
   modport sink   (input valid, label, opened, overflow, cluster_total, output ready);
endinterface

// ----- design/ccc_dist.sv -----
module ccc_dist #(
   parameter int IDX_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ccc_pkg::dist_ctl_type         ctl,
   input  logic [ccc_pkg::PIX_W-1:0]     cen,
   input  logic [ccc_pkg::PIX_W-1:0]     pix,
   input  logic [IDX_W-1:0]              idx,
   output logic [ccc_pkg::DIST_W-1:0]    best_d,
   output logic [IDX_W-1:0]              best_k
);

   localparam int CH_W = ccc_pkg::CH_W;

   logic                         found_ff;
   logic [ccc_pkg::DIST_W-1:0]   best_d_ff;
   logic [IDX_W-1:0]             best_k_ff;
   logic [ccc_pkg::DIST_W-1:0]   cand_d;

   assign cand_d = ccc_pkg::DIST_W'(ccc_pkg::sq_diff(pix[0*CH_W +: CH_W], cen[0*CH_W +: CH_W]))
                 + ccc_pkg::DIST_W'(ccc_pkg::sq_diff(pix[1*CH_W +: CH_W], cen[1*CH_W +: CH_W]))
                 + ccc_pkg::DIST_W'(ccc_pkg::sq_diff(pix[2*CH_W +: CH_W], cen[2*CH_W +: CH_W]));

   // strict compare keeps the lowest index on a tie
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         found_ff <= 1'b0;
      end else if (ctl.load && (!found_ff || cand_d < best_d_ff)) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load && (!found_ff || cand_d < best_d_ff)) begin
         best_d_ff <= cand_d;
         best_k_ff <= idx;
      end
   end

   assign best_d = best_d_ff;
   assign best_k = best_k_ff;

endmodule

// ----- design/ccc_div.sv -----
module ccc_div #(
   parameter int CNT_W = 19
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [CNT_W+ccc_pkg::CH_W-1:0]      dividend,
   input  logic [CNT_W-1:0]                    divisor,
   output logic                                done,
   output logic [ccc_pkg::CH_W-1:0]            quotient
);

   localparam int CH_W   = ccc_pkg::CH_W;
   localparam int STEP_W = $clog2(CH_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CH_W - 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [CH_W-1:0]      q_ff;
   logic [CNT_W:0]       trial;
   logic                 fits;

   // quotient is known to fit in one channel, so the upper dividend bits
   // already form a partial remainder below the divisor
   assign trial = {rem_ff, q_ff[CH_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[CNT_W+CH_W-1:CH_W];
         q_ff   <= dividend[CH_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
         q_ff   <= {q_ff[CH_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- design/chain_color_clustering.sv -----
// channel   direction  handshake            word
// req_ch    in         valid/ready          start_req, blue, green, red
// rsp_ch    out        valid/ready          label, opened, overflow, cluster_total
// csr       in         csr_wr_en            csr_wr_data = threshold
//
// One pixel at a time; the centroid scan reads every cluster in use, one after another.
// Opening a cluster then goes straight to output; joining one runs three divides in
// one shared divider plus decide, sum update, write-back and output (a saturated cluster
// skips the divides and write-back), and the next pixel is taken only back in idle.
// Reset is synchronous; the cluster table needs no clearing pass. req_ch.ready is high
// only while idle; a finished word waits in the rsp_ch register while the next pixel runs.
module chain_color_clustering #(
   parameter int MAX_CLUSTERS = 256,
   parameter int MAX_POINTS   = 262144
) (
   input  logic                            clock,
   input  logic                            reset,
   ccc_req_if.sink                         req_ch,
   ccc_rsp_if.source                       rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [ccc_pkg::THR_W-1:0]       csr_wr_data
);

   localparam int CH_W    = ccc_pkg::CH_W;
   localparam int PIX_W   = ccc_pkg::PIX_W;
   localparam int DIST_W  = ccc_pkg::DIST_W;
   localparam int IDX_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int USED_W  = $clog2(MAX_CLUSTERS + 1);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int SUM_W   = CNT_W + CH_W;
   localparam int ACC_W   = 3 * SUM_W + CNT_W;
   localparam logic [USED_W-1:0] USED_MAX = USED_W'(MAX_CLUSTERS);
   localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_POINTS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_JOIN   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_WRITE  = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   // storage
   logic [PIX_W-1:0] cen_mem [MAX_CLUSTERS];
   logic [ACC_W-1:0] acc_mem [MAX_CLUSTERS];

   logic [2:0]                    state_ff, state_in;
   logic [ccc_pkg::THR_W-1:0]     thr_ff;
   logic [DIST_W-1:0]             thr_sq_ff;
   logic [PIX_W-1:0]              pix_ff, pix_in;
   logic [USED_W-1:0]             used_ff, used_in;
   logic [USED_W-1:0]             issue_ff, issue_in;
   logic                          pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]              pipe_idx_ff, pipe_idx_in;
   logic [PIX_W-1:0]              cen_rd_ff;
   logic [ACC_W-1:0]              acc_rd_ff;
   logic [IDX_W-1:0]              tgt_ff, tgt_in;
   logic                          opened_ff, opened_in;
   logic                          ovf_ff, ovf_in;
   logic [SUM_W-1:0]              sum_b_ff, sum_b_in;
   logic [SUM_W-1:0]              sum_g_ff, sum_g_in;
   logic [SUM_W-1:0]              sum_r_ff, sum_r_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [1:0]                    chan_ff, chan_in;
   logic                          div_go_ff, div_go_in;
   logic [PIX_W-1:0]              new_cen_ff, new_cen_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ccc_pkg::LABEL_W-1:0]   rsp_label_ff, rsp_label_in;
   logic                          rsp_opened_ff, rsp_opened_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;
   logic [ccc_pkg::TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;

   logic                          cen_we;
   logic [IDX_W-1:0]              cen_wa;
   logic [PIX_W-1:0]              cen_wd;
   logic                          acc_we;
   logic [IDX_W-1:0]              acc_wa;
   logic [ACC_W-1:0]              acc_wd;

   ccc_pkg::dist_ctl_type         dist_ctl;
   logic [DIST_W-1:0]             best_d;
   logic [IDX_W-1:0]              best_k;

   logic                          req_acc;
   logic [CNT_W-1:0]              rd_cnt;
   logic [SUM_W-1:0]              rd_sum_b, rd_sum_g, rd_sum_r;
   logic [SUM_W-1:0]              div_dividend;
   logic                          div_done;
   logic [CH_W-1:0]               div_q;
   logic [IDX_W+ccc_pkg::LABEL_W-1:0] label_ext;
   logic [USED_W+ccc_pkg::TOTAL_W-1:0] total_ext;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign rd_cnt   = acc_rd_ff[CNT_W-1:0];
   assign rd_sum_r = acc_rd_ff[CNT_W +: SUM_W];
   assign rd_sum_g = acc_rd_ff[CNT_W+SUM_W +: SUM_W];
   assign rd_sum_b = acc_rd_ff[CNT_W+2*SUM_W +: SUM_W];

   assign div_dividend = (chan_ff == 2'd0) ? sum_b_ff :
                         (chan_ff == 2'd1) ? sum_g_ff : sum_r_ff;

   assign label_ext = {{ccc_pkg::LABEL_W{1'b0}}, tgt_ff};
   assign total_ext = {{ccc_pkg::TOTAL_W{1'b0}}, used_ff};

   ccc_dist #(.IDX_W(IDX_W)) u_dist (
      .clock  (clock),
      .reset  (reset),
      .ctl    (dist_ctl),
      .cen    (cen_rd_ff),
      .pix    (pix_ff),
      .idx    (pipe_idx_ff),
      .best_d (best_d),
      .best_k (best_k)
   );

   ccc_div #(.CNT_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_dividend),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in      = state_ff;
      pix_in        = pix_ff;
      used_in       = used_ff;
      issue_in      = issue_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      tgt_in        = tgt_ff;
      opened_in     = opened_ff;
      ovf_in        = ovf_ff;
      sum_b_in      = sum_b_ff;
      sum_g_in      = sum_g_ff;
      sum_r_in      = sum_r_ff;
      cnt_in        = cnt_ff;
      chan_in       = chan_ff;
      div_go_in     = 1'b0;
      new_cen_in    = new_cen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_label_in  = rsp_label_ff;
      rsp_opened_in = rsp_opened_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_total_in  = rsp_total_ff;
      cen_we        = 1'b0;
      cen_wa        = tgt_ff;
      cen_wd        = new_cen_ff;
      acc_we        = 1'b0;
      acc_wa        = tgt_ff;
      acc_wd        = {sum_b_ff, sum_g_ff, sum_r_ff, cnt_ff};
      dist_ctl.clear = req_acc;
      dist_ctl.load  = pipe_vld_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               pix_in   = {req_ch.red, req_ch.green, req_ch.blue};
               issue_in = '0;
               if (req_ch.start_req) begin
                  used_in = '0;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one centroid read a cycle, compare it the cycle after
            if (issue_ff < used_ff) begin
               issue_in    = issue_ff + USED_W'(1);
               pipe_vld_in = 1'b1;
               pipe_idx_in = issue_ff[IDX_W-1:0];
            end else if (!pipe_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            opened_in = 1'b0;
            ovf_in    = 1'b0;
            tgt_in    = best_k;
            if (used_ff != '0 && best_d < thr_sq_ff) begin
               state_in = ST_JOIN;
            end else if (used_ff < USED_MAX) begin
               tgt_in    = used_ff[IDX_W-1:0];
               cen_we    = 1'b1;
               cen_wa    = used_ff[IDX_W-1:0];
               cen_wd    = pix_ff;
               acc_we    = 1'b1;
               acc_wa    = used_ff[IDX_W-1:0];
               acc_wd    = {SUM_W'(pix_ff[0*CH_W +: CH_W]), SUM_W'(pix_ff[1*CH_W +: CH_W]),
                            SUM_W'(pix_ff[2*CH_W +: CH_W]), CNT_W'(1)};
               used_in   = used_ff + USED_W'(1);
               opened_in = 1'b1;
               state_in  = ST_OUT;
            end else begin
               ovf_in   = 1'b1;
               state_in = ST_JOIN;
            end
         end
         ST_JOIN: begin
            // a saturated cluster keeps its sums, count and centroid
            if (rd_cnt >= CNT_MAX || rd_cnt == '0) begin
               state_in = ST_OUT;
            end else begin
               sum_b_in  = rd_sum_b + SUM_W'(pix_ff[0*CH_W +: CH_W]);
               sum_g_in  = rd_sum_g + SUM_W'(pix_ff[1*CH_W +: CH_W]);
               sum_r_in  = rd_sum_r + SUM_W'(pix_ff[2*CH_W +: CH_W]);
               cnt_in    = rd_cnt + CNT_W'(1);
               acc_we    = 1'b1;
               acc_wa    = tgt_ff;
               acc_wd    = {sum_b_in, sum_g_in, sum_r_in, cnt_in};
               chan_in   = 2'd0;
               div_go_in = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               new_cen_in[chan_ff*CH_W +: CH_W] = div_q;
               if (chan_ff == 2'd2) begin
                  state_in = ST_WRITE;
               end else begin
                  chan_in   = chan_ff + 2'd1;
                  div_go_in = 1'b1;
               end
            end
         end
         ST_WRITE: begin
            cen_we   = 1'b1;
            cen_wa   = tgt_ff;
            cen_wd   = new_cen_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_label_in  = label_ext[ccc_pkg::LABEL_W-1:0];
               rsp_opened_in = opened_ff;
               rsp_ovf_in    = ovf_ff;
               rsp_total_in  = total_ext[ccc_pkg::TOTAL_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= ccc_pkg::THR_RESET;
         thr_sq_ff    <= ccc_pkg::THR_SQ_RESET;
         used_ff      <= '0;
         pipe_vld_ff  <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         thr_sq_ff    <= DIST_W'(thr_ff) * DIST_W'(thr_ff);
         used_ff      <= used_in;
         pipe_vld_ff  <= pipe_vld_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff        <= pix_in;
      issue_ff      <= issue_in;
      pipe_idx_ff   <= pipe_idx_in;
      tgt_ff        <= tgt_in;
      opened_ff     <= opened_in;
      ovf_ff        <= ovf_in;
      sum_b_ff      <= sum_b_in;
      sum_g_ff      <= sum_g_in;
      sum_r_ff      <= sum_r_in;
      cnt_ff        <= cnt_in;
      chan_ff       <= chan_in;
      new_cen_ff    <= new_cen_in;
      rsp_label_ff  <= rsp_label_in;
      rsp_opened_ff <= rsp_opened_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_total_ff  <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (cen_we) begin
         cen_mem[cen_wa] <= cen_wd;
      end
      cen_rd_ff <= cen_mem[issue_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
      acc_rd_ff <= acc_mem[best_k];
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.label         = rsp_label_ff;
   assign rsp_ch.opened        = rsp_opened_ff;
   assign rsp_ch.overflow      = rsp_ovf_ff;
   assign rsp_ch.cluster_total = rsp_total_ff;

endmodule

// ----- design/ccc_checker.sv -----
module ccc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ccc_pkg::LABEL_W-1:0]       rsp_label,
   input logic                              rsp_opened,
   input logic                              rsp_overflow,
   input logic [ccc_pkg::TOTAL_W-1:0]       rsp_cluster_total
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_label)
                                  && $stable(rsp_cluster_total))
      else $error("rsp word changed while stalled");

   // one pixel in flight: ready drops right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while a pixel is in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_opened && rsp_overflow))
      else $error("opened and overflow both set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opened |-> rsp_cluster_total != '0)
      else $error("opened a cluster with an empty table");

endmodule

bind chain_color_clustering ccc_checker u_ccc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_label         (rsp_ch.label),
   .rsp_opened        (rsp_ch.opened),
   .rsp_overflow      (rsp_ch.overflow),
   .rsp_cluster_total (rsp_ch.cluster_total)
);
